// ----- design/fisq_pkg.sv -----
// Shared constants and helpers for the fast inverse square root pipeline.
// No dependencies; used by fisq_fmul, fisq_fadd and fast_inverse_sqrt_float32.
package fisq_pkg;

   localparam logic [31:0] EST_MAGIC = 32'h5F3759DF;
   localparam logic [31:0] FP_HALF = 32'h3F000000;
   localparam logic [31:0] FP_ONE_HALF = 32'h3FC00000;
   localparam logic [31:0] CANON_NAN = 32'h7FC00000;
   localparam logic [7:0] EXP_MAX = 8'hFF;

   // Y_TAPS: estimate delay line length, covers the y use in the last multiply
   localparam int Y_TAPS = 13;

   typedef struct packed {
      logic [23:0] mant;
      logic signed [9:0] expo;
   } unpacked_type;

   typedef struct packed {
      logic nan;
      logic inf;
      logic zero;
      logic sign;
   } flags_type;

   // leading zeros of a 24-bit significand, 24 when zero
   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] cnt;
      cnt = 5'd24;
      for (int i = 0; i < 24; i++) begin
         if (v[i]) cnt = 5'(23 - i);
      end
      return cnt;
   endfunction

   // leading zeros of a 27-bit sum, 27 when zero
   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] cnt;
      cnt = 5'd27;
      for (int i = 0; i < 27; i++) begin
         if (v[i]) cnt = 5'(26 - i);
      end
      return cnt;
   endfunction

   // normalize a finite operand: significand with leading one, unbiased exponent
   function automatic unpacked_type unpack(input logic [31:0] bits);
      unpacked_type u;
      logic [23:0] m;
      logic [4:0] lz;
      m = {(bits[30:23] != 8'd0), bits[22:0]};
      lz = lzc24(m);
      u.mant = m << lz;
      if (bits[30:23] == 8'd0) u.expo = -10'sd126 - $signed({5'd0, lz});
      else u.expo = $signed({2'b00, bits[30:23]}) - 10'sd127;
      return u;
   endfunction

endpackage

// ----- design/fast_inverse_sqrt_float32.sv -----
// Fast inverse square root on binary32 bit patterns: top level.
// Depends on fisq_pkg, fisq_fmul and fisq_fadd.
//
// One operand per cycle, every cycle: busy is always low, so start may be
// held high continuously. Each transfer on req_ gives exactly one result on
// rsp_ (rsp_valid high for one cycle), after the chain of four 3-stage
// multipliers and one 4-stage adder. Results cannot be stalled, so the
// receiver must take rsp_result_bits whenever rsp_valid is high. Arithmetic
// is IEEE single precision, round to nearest even, with subnormals; every
// NaN result is returned as 0x7FC00000.
module fast_inverse_sqrt_float32 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_value_bits,
   output logic        rsp_valid,
   output logic [31:0] rsp_result_bits
);

   logic accept;
   logic [31:0] y_in;
   logic [31:0] y_ff [fisq_pkg::Y_TAPS];

   assign busy = 1'b0;
   assign accept = start & ~busy;

   // integer estimate, wraps modulo 2^32
   assign y_in = fisq_pkg::EST_MAGIC - {1'b0, req_value_bits[31:1]};

   // estimate delay line: y_ff[0] registers y_in, each later tap registers the one before
   always_ff @(posedge clock) begin
      y_ff[0] <= y_in;
      for (int k = 1; k < fisq_pkg::Y_TAPS; k++) begin
         y_ff[k] <= y_ff[k-1];
      end
   end

   logic h_v, t1_v, t2_v, u_v;
   logic [31:0] h_bits, t1_bits, t2_bits, u_bits;

   // h = 0.5 * x
   fisq_fmul u_mul_h (
      .clock(clock), .reset(reset), .in_valid(accept),
      .a_bits(fisq_pkg::FP_HALF), .b_bits(req_value_bits),
      .out_valid(h_v), .result_bits(h_bits)
   );

   // t = h * y, with y from tap y_ff[2] so that it lines up with h
   fisq_fmul u_mul_t1 (
      .clock(clock), .reset(reset), .in_valid(h_v),
      .a_bits(h_bits), .b_bits(y_ff[2]),
      .out_valid(t1_v), .result_bits(t1_bits)
   );

   // t = t * y, with y from tap y_ff[5] so that it lines up with t
   fisq_fmul u_mul_t2 (
      .clock(clock), .reset(reset), .in_valid(t1_v),
      .a_bits(t1_bits), .b_bits(y_ff[5]),
      .out_valid(t2_v), .result_bits(t2_bits)
   );

   // u = 1.5 - t, as an add with the sign of t flipped
   fisq_fadd u_sub_u (
      .clock(clock), .reset(reset), .in_valid(t2_v),
      .a_bits(fisq_pkg::FP_ONE_HALF), .b_bits({~t2_bits[31], t2_bits[30:0]}),
      .out_valid(u_v), .result_bits(u_bits)
   );

   // r = y * u, with y from tap y_ff[12] so that it lines up with u
   fisq_fmul u_mul_r (
      .clock(clock), .reset(reset), .in_valid(u_v),
      .a_bits(y_ff[12]), .b_bits(u_bits),
      .out_valid(rsp_valid), .result_bits(rsp_result_bits)
   );

endmodule

// ----- design/fisq_fmul.sv -----
// Three-stage binary32 multiplier, round to nearest even, gradual underflow.
// Depends on fisq_pkg.
module fisq_fmul (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] a_bits,
   input  logic [31:0] b_bits,
   output logic        out_valid,
   output logic [31:0] result_bits
);

   fisq_pkg::unpacked_type ua, ub;
   fisq_pkg::flags_type fl_in, fl1_ff, fl2_ff;
   logic a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
   logic v1_ff, v2_ff, v3_ff;
   logic [23:0] ma_ff, mb_ff;
   logic signed [10:0] es_in, es1_ff, es2_ff;
   logic [47:0] prod_ff;
   logic [31:0] res_in, res_ff;

   // stage 1: classify and normalize operands
   always_comb begin
      a_nan = (a_bits[30:23] == fisq_pkg::EXP_MAX) && (a_bits[22:0] != 23'd0);
      a_inf = (a_bits[30:23] == fisq_pkg::EXP_MAX) && (a_bits[22:0] == 23'd0);
      a_zero = (a_bits[30:0] == 31'd0);
      b_nan = (b_bits[30:23] == fisq_pkg::EXP_MAX) && (b_bits[22:0] != 23'd0);
      b_inf = (b_bits[30:23] == fisq_pkg::EXP_MAX) && (b_bits[22:0] == 23'd0);
      b_zero = (b_bits[30:0] == 31'd0);
      ua = fisq_pkg::unpack(a_bits);
      ub = fisq_pkg::unpack(b_bits);
      fl_in.nan = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      fl_in.inf = a_inf | b_inf;
      fl_in.zero = a_zero | b_zero;
      fl_in.sign = a_bits[31] ^ b_bits[31];
      es_in = 11'(ua.expo) + 11'(ub.expo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      ma_ff <= ua.mant;
      mb_ff <= ub.mant;
      es1_ff <= es_in;
      fl1_ff <= fl_in;
      // stage 2: significand product
      prod_ff <= ma_ff * mb_ff;
      es2_ff <= es1_ff;
      fl2_ff <= fl1_ff;
      // stage 3: normalize and round
      res_ff <= res_in;
   end

   logic [47:0] q, qs, lost;
   logic signed [10:0] e_biased;
   logic [10:0] sh_full;
   logic [5:0] sh;
   logic [7:0] expf;
   logic [23:0] mant;
   logic inc;
   logic [30:0] rounded;

   always_comb begin
      if (prod_ff[47]) begin
         q = prod_ff;
         e_biased = es2_ff + 11'sd128;
      end else begin
         q = {prod_ff[46:0], 1'b0};
         e_biased = es2_ff + 11'sd127;
      end
      sh_full = 11'(11'sd1 - e_biased);
      if (e_biased >= 11'sd1) begin
         sh = 6'd0;
         expf = e_biased[7:0];
      end else begin
         sh = (sh_full > 11'd50) ? 6'd50 : sh_full[5:0];
         expf = 8'd0;
      end
      {qs, lost} = {q, 48'd0} >> sh;
      mant = qs[47:24];
      inc = qs[23] & ((|qs[22:0]) | (|lost) | mant[0]);
      rounded = {expf, mant[22:0]} + {30'd0, inc};
      if (fl2_ff.nan) res_in = fisq_pkg::CANON_NAN;
      else if (fl2_ff.inf || e_biased >= 11'sd255)
         res_in = {fl2_ff.sign, fisq_pkg::EXP_MAX, 23'd0};
      else if (fl2_ff.zero) res_in = {fl2_ff.sign, 31'd0};
      else res_in = {fl2_ff.sign, rounded};
   end

   assign out_valid = v3_ff;
   assign result_bits = res_ff;

endmodule

// ----- design/fisq_fadd.sv -----
// Four-stage binary32 adder, round to nearest even, gradual underflow.
// Depends on fisq_pkg.
module fisq_fadd (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] a_bits,
   input  logic [31:0] b_bits,
   output logic        out_valid,
   output logic [31:0] result_bits
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic a_nan, a_inf, b_nan, b_inf, swap;
   logic [31:0] x, y;
   fisq_pkg::flags_type fl_in, fl1_ff, fl2_ff, fl3_ff;
   logic sub_in, sub1_ff;
   logic [7:0] ex_in, ex1_ff, ex2_ff, d_in, d1_ff;
   logic [23:0] mx_in, my_in, mx1_ff, my1_ff;

   // stage 1: classify, order by magnitude
   always_comb begin
      a_nan = (a_bits[30:23] == fisq_pkg::EXP_MAX) && (a_bits[22:0] != 23'd0);
      a_inf = (a_bits[30:23] == fisq_pkg::EXP_MAX) && (a_bits[22:0] == 23'd0);
      b_nan = (b_bits[30:23] == fisq_pkg::EXP_MAX) && (b_bits[22:0] != 23'd0);
      b_inf = (b_bits[30:23] == fisq_pkg::EXP_MAX) && (b_bits[22:0] == 23'd0);
      swap = (b_bits[30:0] > a_bits[30:0]);
      x = swap ? b_bits : a_bits;
      y = swap ? a_bits : b_bits;
      fl_in.nan = a_nan | b_nan | (a_inf & b_inf & (a_bits[31] != b_bits[31]));
      fl_in.inf = a_inf | b_inf;
      fl_in.zero = 1'b0;
      fl_in.sign = x[31];
      sub_in = x[31] ^ y[31];
      ex_in = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      d_in = ex_in - ((y[30:23] == 8'd0) ? 8'd1 : y[30:23]);
      mx_in = {(x[30:23] != 8'd0), x[22:0]};
      my_in = {(y[30:23] != 8'd0), y[22:0]};
   end

   // stage 2: align and add
   logic [4:0] dd;
   logic [53:0] wide;
   logic [26:0] ya;
   logic [27:0] sum_in, sum2_ff;
   fisq_pkg::flags_type fl2_in;

   always_comb begin
      dd = (d1_ff > 8'd27) ? 5'd27 : d1_ff[4:0];
      wide = {my1_ff, 3'b000, 27'd0} >> dd;
      ya = wide[53:27] | {26'd0, |wide[26:0]};
      if (sub1_ff) sum_in = {1'b0, mx1_ff, 3'b000} - {1'b0, ya};
      else sum_in = {1'b0, mx1_ff, 3'b000} + {1'b0, ya};
      fl2_in = fl1_ff;
      // exact cancellation rounds to plus zero
      if (sub1_ff && sum_in == 28'd0) fl2_in.sign = 1'b0;
   end

   // stage 3: normalize
   logic [4:0] lz;
   logic [7:0] lim, shl;
   logic [26:0] n_in, n3_ff;
   logic [8:0] e_in, field_in, field3_ff;

   always_comb begin
      lz = fisq_pkg::lzc27(sum2_ff[26:0]);
      lim = ex2_ff - 8'd1;
      shl = ({3'd0, lz} < lim) ? {3'd0, lz} : lim;
      if (sum2_ff[27]) begin
         n_in = {sum2_ff[27:2], sum2_ff[1] | sum2_ff[0]};
         e_in = {1'b0, ex2_ff} + 9'd1;
      end else begin
         n_in = sum2_ff[26:0] << shl;
         e_in = {1'b0, ex2_ff} - {1'b0, shl};
      end
      field_in = n_in[26] ? e_in : 9'd0;
   end

   // stage 4: round
   logic inc;
   logic [30:0] rounded;
   logic [31:0] res_in, res_ff;

   always_comb begin
      inc = n3_ff[2] & (n3_ff[1] | n3_ff[0] | n3_ff[3]);
      rounded = {field3_ff[7:0], n3_ff[25:3]} + {30'd0, inc};
      if (fl3_ff.nan) res_in = fisq_pkg::CANON_NAN;
      else if (fl3_ff.inf || field3_ff >= 9'd255)
         res_in = {fl3_ff.sign, fisq_pkg::EXP_MAX, 23'd0};
      else res_in = {fl3_ff.sign, rounded};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      fl1_ff <= fl_in;
      sub1_ff <= sub_in;
      ex1_ff <= ex_in;
      d1_ff <= d_in;
      mx1_ff <= mx_in;
      my1_ff <= my_in;
      sum2_ff <= sum_in;
      ex2_ff <= ex1_ff;
      fl2_ff <= fl2_in;
      n3_ff <= n_in;
      field3_ff <= field_in;
      fl3_ff <= fl2_ff;
      res_ff <= res_in;
   end

   assign out_valid = v4_ff;
   assign result_bits = res_ff;

endmodule

// ----- bench/fast_inverse_sqrt_float32_tb.sv -----
// Self-checking bench for fast_inverse_sqrt_float32: directed and random operands,
// with a bit-exact binary32 predictor built on integer arithmetic.
// Depends on fisq_pkg for the magic constant, the float constants and the quiet NaN.
module fast_inverse_sqrt_float32_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 9;
   localparam int LATENCY = 16;
   localparam int CALM_TAIL = 200;        // last operands go out back to back
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_COUNT = 1600;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_value_bits;
   logic        rsp_valid;
   logic [31:0] rsp_result_bits;

   fast_inverse_sqrt_float32 uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value_bits(req_value_bits),
      .rsp_valid(rsp_valid),
      .rsp_result_bits(rsp_result_bits)
   );

   // decoded binary32 operand: value = m * 2^q for finite numbers
   typedef struct {
      bit          s;
      logic [23:0] m;
      int          q;
      bit          nan;
      bit          inf;
      bit          zero;
   } fp_parts_type;

   logic [31:0] operand_queue[$];      // operands waiting to be driven
   logic [31:0] expected_rsqrt[$];     // predicted results, oldest first
   int          failures = 0;
   int          cycles = 0;
   int          idle_left = 0;
   bit          took = 0;              // transfer happened at the last rising edge

   function automatic fp_parts_type decode(input logic [31:0] b);
      fp_parts_type f;
      f.s = b[31];
      f.nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
      f.inf = (b[30:23] == 8'hFF) && (b[22:0] == 0);
      f.zero = (b[30:0] == 0);
      f.m = {(b[30:23] != 0), b[22:0]};
      f.q = ((b[30:23] != 0) ? int'(b[30:23]) : 1) - 150;
      return f;
   endfunction

   // round (m + sticky) * 2^q to binary32, nearest even, with gradual underflow
   function automatic logic [31:0] round_pack(input bit s, input logic [127:0] m,
                                              input int q, input bit stk);
      int p, sh, e;
      logic [127:0] rm, rem, half;
      bit up;
      p = -1;
      for (int i = 0; i < 128; i++) if (m[i]) p = i;
      if (p < 0) return {s, 31'b0};
      sh = p - 23;
      if (sh < -149 - q) sh = -149 - q;
      if (sh > 120) begin
         rm = 0;                       // far below half the smallest subnormal
      end else if (sh > 0) begin
         rm = m >> sh;
         rem = m & ((128'd1 << sh) - 1);
         half = 128'd1 << (sh - 1);
         up = (rem > half) || (rem == half && (stk || rm[0]));
         rm = rm + up;
      end else begin
         rm = m << (-sh);
      end
      if (rm[24]) begin
         rm = rm >> 1;
         sh++;
      end
      if (!rm[23]) return {s, 8'h00, rm[22:0]};
      e = q + sh + 150;
      if (e >= 255) return {s, 8'hFF, 23'b0};
      return {s, e[7:0], rm[22:0]};
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      fp_parts_type x, y;
      bit s;
      x = decode(a);
      y = decode(b);
      s = x.s ^ y.s;
      if (x.nan || y.nan || (x.inf && y.zero) || (x.zero && y.inf))
         return fisq_pkg::CANON_NAN;
      if (x.inf || y.inf) return {s, 8'hFF, 23'b0};
      if (x.zero || y.zero) return {s, 31'b0};
      return round_pack(s, 128'(x.m) * 128'(y.m), x.q + y.q, 1'b0);
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      fp_parts_type x, y, big, lit;
      int d;
      logic [127:0] xa, ya, ys;
      bit stk;
      x = decode(a);
      y = decode(b);
      if (x.nan || y.nan) return fisq_pkg::CANON_NAN;
      if (x.inf && y.inf) return (x.s == y.s) ? a : fisq_pkg::CANON_NAN;
      if (x.inf) return a;
      if (y.inf) return b;
      if (x.zero && y.zero) return {x.s & y.s, 31'b0};
      if (x.zero) return b;
      if (y.zero) return a;
      big = x;
      lit = y;
      if (y.q > x.q) begin
         big = y;
         lit = x;
      end
      d = big.q - lit.q;
      // 40 extra low bits keep the smaller operand exact or leave a sticky bit
      xa = 128'(big.m) << 40;
      ys = 128'(lit.m);
      stk = 0;
      if (d <= 40) begin
         ya = ys << (40 - d);
      end else if (d - 40 > 100) begin
         ya = 0;
         stk = 1;
      end else begin
         ya = ys >> (d - 40);
         stk = ((ya << (d - 40)) != ys);
      end
      if (big.s == lit.s) return round_pack(big.s, xa + ya, big.q - 40, stk);
      if (xa > ya || (xa == ya && stk))
         return round_pack(big.s, xa - ya - 128'(stk), big.q - 40, stk);
      if (xa == ya) return 32'h0;
      return round_pack(lit.s, ya - xa, big.q - 40, 1'b0);
   endfunction

   // integer estimate, then one Newton step, each operation rounded on its own
   function automatic logic [31:0] predict_rsqrt(input logic [31:0] xb);
      logic [31:0] y, h, t, u, r;
      y = fisq_pkg::EST_MAGIC - (xb >> 1);
      h = fp_mul(fisq_pkg::FP_HALF, xb);
      t = fp_mul(h, y);
      t = fp_mul(t, y);
      u = fp_add(fisq_pkg::FP_ONE_HALF, t ^ 32'h80000000);
      r = fp_mul(y, u);
      if (r[30:23] == 8'hFF && r[22:0] != 0) return fisq_pkg::CANON_NAN;
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // driver: a new operand is picked only after the previous one transferred
   always @(negedge clock) begin
      if (reset) begin
         start <= 0;
         req_value_bits <= 0;
      end else if (!start || took) begin
         if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            start <= 0;
         end else if (operand_queue.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
            idle_left <= $urandom_range(0, 6);
            start <= 0;
         end else if (operand_queue.size() > 0) begin
            start <= 1;
            req_value_bits <= operand_queue.pop_front();
         end else begin
            start <= 0;
         end
      end
   end

   // monitor: record transfers, check strobed results against the oldest prediction
   always @(posedge clock) begin
      logic [31:0] want;
      cycles <= cycles + 1;
      took <= !reset && start && !busy;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsqrt.size() == 0) begin
               $error("unexpected result: result_bits actual %h", rsp_result_bits);
               failures <= failures + 1;
            end else begin
               want = expected_rsqrt.pop_front();
               if (rsp_result_bits !== want) begin
                  $error("result_bits mismatch: expected %h actual %h", want,
                         rsp_result_bits);
                  failures <= failures + 1;
               end
            end
         end
         if (start && !busy) expected_rsqrt.push_back(predict_rsqrt(req_value_bits));
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic [31:0] v;
      int kind;
      reset = 1;
      start = 0;
      req_value_bits = 0;
      // directed: zeros, infinities, NaNs, subnormal and normal edges, negatives
      operand_queue = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                        32'h7FC00000, 32'h7F800001, 32'hFFC00000, 32'hFFFFFFFF,
                        32'h00000001, 32'h007FFFFF, 32'h00800000, 32'h7F7FFFFF,
                        32'h3F800000, 32'h40800000, 32'h3E800000, 32'hBF800000,
                        32'h80000001, 32'hFF7FFFFF, 32'h807FFFFF, 32'h5F3759DF,
                        32'hBEFFFFFF, 32'h3FFFFFFF, 32'h7FFFFFFF};
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         kind = $urandom_range(0, 9);
         v = $urandom;
         if (kind < 5) v[31:23] = {1'b0, 8'($urandom_range(1, 254))};  // positive normal
         else if (kind == 5) v[30:23] = 0;                             // subnormal
         else if (kind == 6) v[30:23] = 8'hFF;                         // inf or NaN
         operand_queue.push_back(v);
      end
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 0;
      wait (operand_queue.size() == 0);
      @(posedge clock);
      while (start) @(posedge clock);
      while (expected_rsqrt.size() > 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (failures == 0 && expected_rsqrt.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
